### hdl/sitda_pkg.sv
// shared types and constants of the signed integer to decimal text converter
`default_nettype none

package sitda_pkg;

    localparam int CODE_W  = 7;   // ascii character code
    localparam int CHAR_W  = 4;   // character count and limit register
    localparam int DIGIT_W = 4;   // one bcd digit

    localparam logic [CHAR_W-1:0]  MAX_RESULTS = 4'd11;
    localparam logic [CHAR_W-1:0]  LIMIT_RESET = 4'd11;
    localparam logic [CODE_W-1:0]  CHAR_ZERO   = 7'h30;
    localparam logic [CODE_W-1:0]  CHAR_MINUS  = 7'h2D;
    localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD = 4'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic conv;
        logic size;
        logic trim;
        logic emit;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic conv_done;
        logic len_zero;
        logic emit_last;
    } t_dp_sts;

endpackage

`default_nettype wire

### hdl/signed_int_to_decimal_ascii_core.sv
// top level of the signed integer to decimal ascii text converter
`default_nettype none

// Converts one signed VALUE_BITS-bit value per transaction into its decimal
// text, one character per o_strobe cycle, most significant first, with a
// leading minus for negative values and o_last on the final character. Text
// is cut after i_cfg_char_limit characters (12 to 15 act as 11, 0 sends
// nothing). A transaction is taken when start is high and busy is low; busy
// stays high until the last character has been sent. The receiver cannot
// stall: each character is on the ports for exactly one cycle. Each value
// passes through a load step, the two-bit-per-cycle shift-add-3 converter,
// a sizing step and a trim step, then one character per cycle. The limit
// register is written only while busy is low.

module signed_int_to_decimal_ascii_core #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [VALUE_BITS-1:0] i_value,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [sitda_pkg::CHAR_W-1:0] i_cfg_char_limit,
    output logic                              o_strobe,
    output logic [sitda_pkg::CODE_W-1:0]      o_char_code,
    output logic                              o_last
);
    import sitda_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // the limit may only change between values
    assign o_cfg_ready = !busy;
    assign o_strobe    = w_cmd.emit;

    sitda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    sitda_dp #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_value     (i_value),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_data  (i_cfg_char_limit),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

### hdl/sitda_ctrl.sv
// controller state machine of the signed integer to decimal text converter
`default_nettype none

module sitda_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire sitda_pkg::t_dp_sts i_sts,
    output sitda_pkg::t_dp_cmd     o_cmd,
    output logic                   o_busy
);
    import sitda_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_SIZE = 5'b00100,
        S_TRIM = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                if (i_sts.conv_done) begin
                    n_state = S_SIZE;
                end
            end
            S_SIZE: begin
                o_cmd.size = 1'b1;
                n_state    = S_TRIM;
            end
            S_TRIM: begin
                o_cmd.trim = 1'b1;
                // a limit of zero leaves nothing to send
                n_state    = i_sts.len_zero ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && i_sts.emit_last) |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after last character");

    a_start_to_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_CONV))
        else $error("accepted transaction did not start conversion");

    a_conv_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV && !i_sts.conv_done) |=> (r_state == S_CONV))
        else $error("conversion left early");

endmodule

`default_nettype wire

### hdl/sitda_dp.sv
// datapath: shift-add-3 binary to bcd converter, sizing and character output
`default_nettype none

module sitda_dp #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire sitda_pkg::t_dp_cmd           i_cmd,
    output sitda_pkg::t_dp_sts                o_sts,
    input  wire logic signed [VALUE_BITS-1:0] i_value,
    input  wire logic                         i_cfg_we,
    input  wire logic [sitda_pkg::CHAR_W-1:0] i_cfg_data,
    output logic [sitda_pkg::CODE_W-1:0]      o_char_code,
    output logic                              o_last
);
    import sitda_pkg::*;

    localparam int PAD_BITS = VALUE_BITS + (VALUE_BITS % 2);
    localparam int STEPS    = PAD_BITS / 2;
    localparam int CNT_W    = $clog2(STEPS);
    localparam int BCD_BITS = MAX_DIGITS * DIGIT_W;
    localparam int DIG_W    = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W    = $clog2(MAX_DIGITS);
    localparam int LEN_W    = DIG_W + 1;

    logic [CHAR_W-1:0]   r_char_limit;
    logic [PAD_BITS-1:0] r_shift;
    logic [BCD_BITS-1:0] r_bcd;
    logic                r_ovf;
    logic                r_neg;
    logic [CNT_W-1:0]    r_cnt;
    logic [DIG_W-1:0]    r_ndig;
    logic [IDX_W-1:0]    r_ptr;
    logic [CHAR_W-1:0]   r_remain;
    logic                r_minus_pending;

    logic [VALUE_BITS-1:0] w_raw;
    logic [VALUE_BITS-1:0] w_mag;
    logic [PAD_BITS-1:0]   n_shift;
    logic [BCD_BITS-1:0]   n_bcd;
    logic                  n_ovf;
    logic [DIG_W-1:0]      n_ndig;
    logic [LEN_W-1:0]      w_len;
    logic [CHAR_W-1:0]     w_lim;
    logic [CHAR_W-1:0]     w_nchar;
    logic [DIGIT_W-1:0]    w_digit;

    // magnitude taken unsigned so the most negative value converts fully
    assign w_raw = $unsigned(i_value);
    assign w_mag = w_raw[VALUE_BITS-1] ? (~w_raw + 1'b1) : w_raw;

    // two shift-add-3 steps per cycle
    always_comb begin
        n_bcd   = r_bcd;
        n_shift = r_shift;
        n_ovf   = r_ovf;
        for (int s = 0; s < 2; s++) begin
            for (int d = 0; d < MAX_DIGITS; d++) begin
                if (n_bcd[d*DIGIT_W +: DIGIT_W] >= BCD_ADJ_MIN) begin
                    n_bcd[d*DIGIT_W +: DIGIT_W] = n_bcd[d*DIGIT_W +: DIGIT_W] + BCD_ADJ_ADD;
                end
            end
            // carry out of the top digit means digits beyond capacity exist
            n_ovf   = n_ovf | n_bcd[BCD_BITS-1];
            n_bcd   = {n_bcd[BCD_BITS-2:0], n_shift[PAD_BITS-1]};
            n_shift = {n_shift[PAD_BITS-2:0], 1'b0};
        end
    end

    // digit count: highest nonzero digit, at least one, full when truncated
    always_comb begin
        n_ndig = DIG_W'(1);
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (r_bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
                n_ndig = DIG_W'(d + 1);
            end
        end
        if (r_ovf) begin
            n_ndig = DIG_W'(MAX_DIGITS);
        end
    end

    assign w_len   = LEN_W'(r_ndig) + LEN_W'(r_neg);
    assign w_lim   = (r_char_limit > MAX_RESULTS) ? MAX_RESULTS : r_char_limit;
    assign w_nchar = (w_len > LEN_W'(w_lim)) ? w_lim : w_len[CHAR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_char_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_shift <= PAD_BITS'(w_mag);
            r_bcd   <= '0;
            r_ovf   <= 1'b0;
            r_neg   <= w_raw[VALUE_BITS-1];
            r_cnt   <= '0;
        end
        if (i_cmd.conv) begin
            r_shift <= n_shift;
            r_bcd   <= n_bcd;
            r_ovf   <= n_ovf;
            r_cnt   <= r_cnt + 1'b1;
        end
        if (i_cmd.size) begin
            r_ndig <= n_ndig;
        end
        if (i_cmd.trim) begin
            r_remain        <= w_nchar;
            r_ptr           <= IDX_W'(r_ndig - 1'b1);
            r_minus_pending <= r_neg;
        end
        if (i_cmd.emit) begin
            r_remain <= r_remain - 1'b1;
            if (r_minus_pending) begin
                r_minus_pending <= 1'b0;
            end else begin
                r_ptr <= r_ptr - 1'b1;
            end
        end
    end

    assign w_digit = ({1'b0, r_ptr} < (IDX_W + 1)'(MAX_DIGITS))
                   ? r_bcd[r_ptr*DIGIT_W +: DIGIT_W] : '0;

    assign o_char_code = r_minus_pending ? CHAR_MINUS
                                         : (CHAR_ZERO + CODE_W'(w_digit));
    assign o_last      = (r_remain == CHAR_W'(1));

    assign o_sts.conv_done = (r_cnt == CNT_W'(STEPS - 1));
    assign o_sts.len_zero  = (w_nchar == '0);
    assign o_sts.emit_last = o_last;

    a_emit_has_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_remain != '0))
        else $error("character sent with no count left");

    a_emit_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && !r_minus_pending) |-> ({1'b0, r_ptr} < (IDX_W + 1)'(MAX_DIGITS)))
        else $error("digit pointer out of range");

endmodule

`default_nettype wire

### bench/sitda_checker.sv
// checker: predicts the decimal text of each value and compares the character stream
`timescale 1ns / 100ps

module sitda_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic                         i_busy,
    input  wire logic signed [31:0]           i_value,
    input  wire logic                         i_cfg_valid,
    input  wire logic                         i_cfg_ready,
    input  wire logic [sitda_pkg::CHAR_W-1:0] i_cfg_char_limit,
    input  wire logic                         i_strobe,
    input  wire logic [sitda_pkg::CODE_W-1:0] i_char_code,
    input  wire logic                         i_last,
    output int                                o_mismatch_count,
    output int                                o_chars_pending
);
    import sitda_pkg::*;

    localparam int DIGIT_SLOTS = 16;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } t_char_exp;

    t_char_exp         expected_chars[$];
    logic [CHAR_W-1:0] char_limit_copy;

    // builds the text of one value and queues the characters that survive the limit
    function automatic void predict_text(input logic [31:0] raw, input logic [CHAR_W-1:0] lim);
        logic              negative;
        logic [31:0]       mag;
        logic [31:0]       rem;
        logic [3:0]        digits[DIGIT_SLOTS];
        logic [CODE_W-1:0] text[DIGIT_SLOTS+1];
        int                ndig;
        int                len;
        int                cap;
        int                i;
        t_char_exp         item;
        negative = raw[31];
        // unsigned negate, so the most negative value keeps its full magnitude
        mag      = negative ? (~raw + 32'd1) : raw;
        ndig     = 0;
        len      = 0;
        if (mag == 32'd0) begin
            digits[0] = 4'd0;
            ndig      = 1;
        end else begin
            while (mag != 32'd0 && ndig < DIGIT_SLOTS) begin
                rem          = mag % 32'd10;
                digits[ndig] = rem[3:0];
                mag          = mag / 32'd10;
                ndig++;
            end
        end
        if (negative) begin
            text[len] = CHAR_MINUS;
            len++;
        end
        for (i = ndig - 1; i >= 0; i--) begin
            text[len] = CHAR_ZERO + {3'b000, digits[i]};
            len++;
        end
        cap = (lim > MAX_RESULTS) ? int'(MAX_RESULTS) : int'(lim);
        if (len > cap) begin
            len = cap;
        end
        for (i = 0; i < len; i++) begin
            item.code = text[i];
            item.last = (i == len - 1);
            expected_chars.push_back(item);
        end
    endfunction

    always @(posedge i_clk) begin
        t_char_exp want;
        if (!i_rst_n) begin
            char_limit_copy = LIMIT_RESET;
            expected_chars.delete();
            o_mismatch_count = 0;
        end else begin
            // characters of an earlier value are checked before a new value is queued
            if (i_strobe) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t ns: character with none expected: got code %h last %b",
                             $time, i_char_code, i_last);
                    o_mismatch_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (want.code !== i_char_code) begin
                        $display("%0t ns: char_code mismatch: expected %h got %h",
                                 $time, want.code, i_char_code);
                        o_mismatch_count++;
                    end
                    if (want.last !== i_last) begin
                        $display("%0t ns: last mismatch: expected %b got %b",
                                 $time, want.last, i_last);
                        o_mismatch_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                char_limit_copy = i_cfg_char_limit;
            end
            if (i_start && !i_busy) begin
                predict_text(i_value, char_limit_copy);
            end
        end
        o_chars_pending = expected_chars.size();
    end

endmodule

### bench/tb.sv
// testbench top: drives values and limit writes into the converter and gives the verdict
`timescale 1ns / 100ps

module tb;
    import sitda_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 32;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 16;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic signed [31:0]       i_value;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CHAR_W-1:0]        i_cfg_char_limit;
    logic                     o_strobe;
    logic [CODE_W-1:0]        o_char_code;
    logic                     o_last;

    int mismatch_count;
    int chars_pending;
    int cycle_count = 0;
    bit idle_on;

    signed_int_to_decimal_ascii_core #(
        .VALUE_BITS(32),
        .MAX_DIGITS(16)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_value          (i_value),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_char_limit (i_cfg_char_limit),
        .o_strobe         (o_strobe),
        .o_char_code      (o_char_code),
        .o_last           (o_last)
    );

    sitda_checker u_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_value          (i_value),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_char_limit (i_cfg_char_limit),
        .i_strobe         (o_strobe),
        .i_char_code      (o_char_code),
        .i_last           (o_last),
        .o_mismatch_count (mismatch_count),
        .o_chars_pending  (chars_pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // occasional gap before the next transaction
    task automatic maybe_pause(ref logic strobe_sig);
        if (idle_on && $urandom_range(99) < 6) begin
            @(negedge i_clk);
            strobe_sig = 1'b0;
            repeat ($urandom_range(3)) @(negedge i_clk);
        end
    endtask

    // start stays high between back-to-back values; the next negedge decides
    task automatic send_value(input logic [31:0] v);
        maybe_pause(start);
        @(negedge i_clk);
        start   <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (busy);
    endtask

    // wait for all characters and for a value that sends none to finish
    task automatic quiesce();
        @(negedge i_clk);
        start <= 1'b0;
        while (chars_pending != 0 || busy) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_char_limit(input logic [CHAR_W-1:0] lim);
        quiesce();
        maybe_pause(i_cfg_valid);
        @(negedge i_clk);
        i_cfg_valid      <= 1'b1;
        i_cfg_char_limit <= lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        int          k;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom_range(999);
            2: v = {1'b0, 3'b111, 28'($urandom)};
            default: begin
                v = 32'd1;
                for (k = $urandom_range(9); k > 0; k--) begin
                    v = v * 32'd10;
                end
                v = v + $urandom_range(2) - 32'd1;
            end
        endcase
        if ($urandom_range(1)) begin
            v = -v;
        end
        return v;
    endfunction

    initial begin
        int ph;
        int n;
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_value          = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_char_limit = '0;
        idle_on          = 1'b1;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset limit: full text of the extremes
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'd9);
        send_value(32'd10);
        send_value(-32'sd10);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd1000000000);
        send_value(-32'sd999999999);
        send_value(32'h5555_5555);
        send_value(32'hAAAA_AAAA);

        // zero limit sends nothing
        set_char_limit(4'd0);
        send_value(-32'sd5);
        send_value(32'd123);

        // values above eleven act as eleven
        set_char_limit(4'd15);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        set_char_limit(4'd12);
        send_value(-32'sd1234567890);

        // text cut to the leading characters
        set_char_limit(4'd1);
        send_value(-32'sd7);
        send_value(32'd42);
        set_char_limit(4'd3);
        send_value(-32'sd12345);
        send_value(32'd100);
        set_char_limit(4'd11);
        send_value(32'd7);

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_char_limit(ph == 0 ? 4'd11 : 4'($urandom_range(15)));
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // one long stretch without gaps
                idle_on = !(ph == 2);
                send_value(pick_value());
            end
        end
        idle_on = 1'b1;

        quiesce();
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
